### hdl/rmq_pkg.sv
package rmq_pkg;

  localparam int WORD_BITS   = 16;
  localparam int FRAC_BITS   = WORD_BITS - 2;
  localparam int EXT_BITS    = WORD_BITS + 3;
  localparam int RAD_BITS    = WORD_BITS + 1;
  localparam int SQ_RAW_BITS = RAD_BITS + FRAC_BITS;
  localparam int SQ_IN_BITS  = SQ_RAW_BITS + (SQ_RAW_BITS % 2);
  localparam int ROOT_BITS   = SQ_IN_BITS / 2;
  localparam int REM_BITS    = ROOT_BITS + 2;
  localparam int MAG_BITS    = WORD_BITS + 1;
  localparam int NUM_BITS    = MAG_BITS + FRAC_BITS;
  localparam int DVS_BITS    = ROOT_BITS + 1;
  localparam int DW_BITS     = DVS_BITS + WORD_BITS;
  localparam int LANES       = 3;
  localparam int PIPE_LATENCY = 1 + ROOT_BITS + 1 + WORD_BITS + 1;

  localparam logic [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  typedef enum logic [1:0] {
    SLOT_W = 2'd0,
    SLOT_X = 2'd1,
    SLOT_Y = 2'd2,
    SLOT_Z = 2'd3
  } slot_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] m00;
    logic signed [WORD_BITS-1:0] m01;
    logic signed [WORD_BITS-1:0] m02;
    logic signed [WORD_BITS-1:0] m10;
    logic signed [WORD_BITS-1:0] m11;
    logic signed [WORD_BITS-1:0] m12;
    logic signed [WORD_BITS-1:0] m20;
    logic signed [WORD_BITS-1:0] m21;
    logic signed [WORD_BITS-1:0] m22;
  } in_item_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] quat_w;
    logic signed [WORD_BITS-1:0] quat_x;
    logic signed [WORD_BITS-1:0] quat_y;
    logic signed [WORD_BITS-1:0] quat_z;
    logic                        bad_matrix;
  } out_item_t;

  typedef struct packed {
    logic                          bad;
    slot_t                         lead;
    slot_t                         dst_a;
    slot_t                         dst_b;
    slot_t                         dst_c;
    logic [LANES-1:0]              neg;
    logic [LANES-1:0][MAG_BITS-1:0] mag;
  } ctl_t;

  typedef struct packed {
    logic                 bad;
    slot_t                lead;
    slot_t                dst_a;
    slot_t                dst_b;
    slot_t                dst_c;
    logic [LANES-1:0]     neg;
    logic [WORD_BITS-1:0] lead_val;
  } tag_t;

  function automatic logic signed [EXT_BITS-1:0] sx(input logic signed [WORD_BITS-1:0] v);
    return EXT_BITS'(v);
  endfunction

endpackage

### hdl/rmq_front.sv
module rmq_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  rmq_pkg::in_item_t in_item,
  output logic              valid_r,
  output logic [rmq_pkg::RAD_BITS-1:0] rad_r,
  output rmq_pkg::ctl_t     ctl_r
);

  localparam int EB = rmq_pkg::EXT_BITS;
  localparam logic signed [EB-1:0] EXT_ONE = EB'(2 ** rmq_pkg::FRAC_BITS);

  logic signed [EB-1:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;
  logic signed [EB-1:0] trace, rad;
  logic signed [EB-1:0] d [rmq_pkg::LANES];
  logic [rmq_pkg::RAD_BITS-1:0] rad_nxt;
  rmq_pkg::ctl_t ctl_nxt;
  logic trace_pos;
  logic [1:0] idx;

  always_comb begin
    a00 = rmq_pkg::sx(in_item.m00);
    a01 = rmq_pkg::sx(in_item.m01);
    a02 = rmq_pkg::sx(in_item.m02);
    a10 = rmq_pkg::sx(in_item.m10);
    a11 = rmq_pkg::sx(in_item.m11);
    a12 = rmq_pkg::sx(in_item.m12);
    a20 = rmq_pkg::sx(in_item.m20);
    a21 = rmq_pkg::sx(in_item.m21);
    a22 = rmq_pkg::sx(in_item.m22);
    trace = a00 + a11 + a22;
    trace_pos = trace > 0;
    idx = 2'd0;
    if (a11 > a00) idx = 2'd1;
    if ((idx == 2'd1) ? (a22 > a11) : (a22 > a00)) idx = 2'd2;
    ctl_nxt = '0;
    if (trace_pos) begin
      rad = trace + EXT_ONE;
      d[0] = a21 - a12;
      d[1] = a02 - a20;
      d[2] = a10 - a01;
      ctl_nxt.lead  = rmq_pkg::SLOT_W;
      ctl_nxt.dst_a = rmq_pkg::SLOT_X;
      ctl_nxt.dst_b = rmq_pkg::SLOT_Y;
      ctl_nxt.dst_c = rmq_pkg::SLOT_Z;
    end else begin
      ctl_nxt.dst_a = rmq_pkg::SLOT_W;
      case (idx)
        2'd1: begin
          rad = a11 - a22 - a00 + EXT_ONE;
          d[0] = a02 - a20;
          d[1] = a21 + a12;
          d[2] = a01 + a10;
          ctl_nxt.lead  = rmq_pkg::SLOT_Y;
          ctl_nxt.dst_b = rmq_pkg::SLOT_Z;
          ctl_nxt.dst_c = rmq_pkg::SLOT_X;
        end
        2'd2: begin
          rad = a22 - a00 - a11 + EXT_ONE;
          d[0] = a10 - a01;
          d[1] = a02 + a20;
          d[2] = a12 + a21;
          ctl_nxt.lead  = rmq_pkg::SLOT_Z;
          ctl_nxt.dst_b = rmq_pkg::SLOT_X;
          ctl_nxt.dst_c = rmq_pkg::SLOT_Y;
        end
        default: begin
          rad = a00 - a11 - a22 + EXT_ONE;
          d[0] = a21 - a12;
          d[1] = a10 + a01;
          d[2] = a20 + a02;
          ctl_nxt.lead  = rmq_pkg::SLOT_X;
          ctl_nxt.dst_b = rmq_pkg::SLOT_Y;
          ctl_nxt.dst_c = rmq_pkg::SLOT_Z;
        end
      endcase
    end
    ctl_nxt.bad = (rad <= 0);
    rad_nxt = ctl_nxt.bad ? '0 : rad[rmq_pkg::RAD_BITS-1:0];
    for (int l = 0; l < rmq_pkg::LANES; l++) begin
      ctl_nxt.neg[l] = d[l][EB-1];
      ctl_nxt.mag[l] = d[l][EB-1] ? rmq_pkg::MAG_BITS'(-d[l])
                                  : rmq_pkg::MAG_BITS'(d[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
    rad_r <= rad_nxt;
    ctl_r <= ctl_nxt;
  end

endmodule

### hdl/rmq_sqrt.sv
module rmq_sqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [rmq_pkg::RAD_BITS-1:0]  rad,
  input  rmq_pkg::ctl_t                 ctl,
  output logic                          out_valid,
  output logic [rmq_pkg::ROOT_BITS-1:0] root,
  output rmq_pkg::ctl_t                 out_ctl
);

  localparam int STEPS = rmq_pkg::ROOT_BITS;
  localparam int RM    = rmq_pkg::REM_BITS;
  localparam int XB    = rmq_pkg::SQ_IN_BITS;

  logic                 val_r  [STEPS];
  logic [RM-1:0]        rem_r  [STEPS];
  logic [STEPS-1:0]     root_r [STEPS];
  logic [XB-1:0]        x_r    [STEPS];
  rmq_pkg::ctl_t        ctl_r  [STEPS];

  for (genvar s = 0; s < STEPS; s++) begin : g_step
    logic             p_val;
    logic [RM-1:0]    p_rem;
    logic [STEPS-1:0] p_root;
    logic [XB-1:0]    p_x;
    rmq_pkg::ctl_t    p_ctl;
    logic [RM+1:0]    cand, sub, diff;
    logic             ge;

    if (s == 0) begin : g_in
      assign p_val  = in_valid;
      assign p_rem  = '0;
      assign p_root = '0;
      assign p_x    = XB'({rad, {rmq_pkg::FRAC_BITS{1'b0}}});
      assign p_ctl  = ctl;
    end else begin : g_prev
      assign p_val  = val_r[s-1];
      assign p_rem  = rem_r[s-1];
      assign p_root = root_r[s-1];
      assign p_x    = x_r[s-1];
      assign p_ctl  = ctl_r[s-1];
    end

    always_comb begin
      cand = {p_rem, p_x[XB-1 -: 2]};
      sub  = {{(RM-STEPS){1'b0}}, p_root, 2'b01};
      ge   = cand >= sub;
      diff = cand - sub;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        val_r[s] <= 1'b0;
      end else begin
        val_r[s] <= p_val;
      end
      rem_r[s]  <= ge ? diff[RM-1:0] : cand[RM-1:0];
      root_r[s] <= {p_root[STEPS-2:0], ge};
      x_r[s]    <= p_x << 2;
      ctl_r[s]  <= p_ctl;
    end
  end

  assign out_valid = val_r[STEPS-1];
  assign root      = root_r[STEPS-1];
  assign out_ctl   = ctl_r[STEPS-1];

endmodule

### hdl/rmq_div.sv
module rmq_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [rmq_pkg::ROOT_BITS-1:0] root,
  input  rmq_pkg::ctl_t                 ctl,
  output logic                          out_valid,
  output logic [rmq_pkg::LANES-1:0][rmq_pkg::WORD_BITS-1:0] quo,
  output logic [rmq_pkg::LANES-1:0]     ovf,
  output rmq_pkg::tag_t                 out_tag
);

  localparam int W  = rmq_pkg::WORD_BITS;
  localparam int NB = rmq_pkg::NUM_BITS;
  localparam int DB = rmq_pkg::DVS_BITS;
  localparam int DW = rmq_pkg::DW_BITS;
  localparam int L  = rmq_pkg::LANES;
  localparam int RB = rmq_pkg::ROOT_BITS;

  logic                    pv_r;
  logic [L-1:0][NB-1:0]    pnum_r;
  logic [L-1:0]            povf_r;
  logic [DB-1:0]           pdvs_r;
  rmq_pkg::tag_t           ptag_r;

  logic [L-1:0][NB-1:0]    num_nxt;
  logic [L-1:0]            ovf_nxt;
  logic [DB-1:0]           dvs;
  logic [RB:0]             lead_sum;
  logic [RB-1:0]           lead_half;
  rmq_pkg::tag_t           tag_nxt;

  always_comb begin
    dvs = {root, 1'b0};
    for (int l = 0; l < L; l++) begin
      num_nxt[l] = NB'({ctl.mag[l], {rmq_pkg::FRAC_BITS{1'b0}}}) + NB'(root);
      ovf_nxt[l] = DW'(num_nxt[l]) >= {dvs, {W{1'b0}}};
    end
    lead_sum  = (RB+1)'(root) + (RB+1)'(1);
    lead_half = lead_sum[RB:1];
    tag_nxt.bad   = ctl.bad;
    tag_nxt.lead  = ctl.lead;
    tag_nxt.dst_a = ctl.dst_a;
    tag_nxt.dst_b = ctl.dst_b;
    tag_nxt.dst_c = ctl.dst_c;
    tag_nxt.neg   = ctl.neg;
    tag_nxt.lead_val = ((RB+1)'(lead_half) > (RB+1)'(rmq_pkg::WORD_MAX))
                       ? rmq_pkg::WORD_MAX : W'(lead_half);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else begin
      pv_r <= in_valid;
    end
    pnum_r <= num_nxt;
    povf_r <= ovf_nxt;
    pdvs_r <= dvs;
    ptag_r <= tag_nxt;
  end

  logic                 val_r  [W];
  logic [L-1:0][NB-1:0] rem_r  [W];
  logic [L-1:0][W-1:0]  q_r    [W];
  logic [L-1:0]         ovf_r  [W];
  logic [DB-1:0]        dvs_r  [W];
  rmq_pkg::tag_t        tag_r  [W];

  for (genvar s = 0; s < W; s++) begin : g_bit
    localparam int SH = W - 1 - s;
    logic                 p_val;
    logic [L-1:0][NB-1:0] p_rem;
    logic [L-1:0][W-1:0]  p_q;
    logic [L-1:0]         p_ovf;
    logic [DB-1:0]        p_dvs;
    rmq_pkg::tag_t        p_tag;
    logic [DW-1:0]        sh;
    logic [L-1:0][NB-1:0] rem_nxt;
    logic [L-1:0][W-1:0]  q_nxt;

    if (s == 0) begin : g_in
      assign p_val = pv_r;
      assign p_rem = pnum_r;
      assign p_q   = '0;
      assign p_ovf = povf_r;
      assign p_dvs = pdvs_r;
      assign p_tag = ptag_r;
    end else begin : g_prev
      assign p_val = val_r[s-1];
      assign p_rem = rem_r[s-1];
      assign p_q   = q_r[s-1];
      assign p_ovf = ovf_r[s-1];
      assign p_dvs = dvs_r[s-1];
      assign p_tag = tag_r[s-1];
    end

    always_comb begin
      sh = DW'(p_dvs) << SH;
      for (int l = 0; l < L; l++) begin
        if (DW'(p_rem[l]) >= sh) begin
          rem_nxt[l] = NB'(DW'(p_rem[l]) - sh);
          q_nxt[l]   = {p_q[l][W-2:0], 1'b1};
        end else begin
          rem_nxt[l] = p_rem[l];
          q_nxt[l]   = {p_q[l][W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        val_r[s] <= 1'b0;
      end else begin
        val_r[s] <= p_val;
      end
      rem_r[s] <= rem_nxt;
      q_r[s]   <= q_nxt;
      ovf_r[s] <= p_ovf;
      dvs_r[s] <= p_dvs;
      tag_r[s] <= p_tag;
    end
  end

  assign out_valid = val_r[W-1];
  assign quo       = q_r[W-1];
  assign ovf       = ovf_r[W-1];
  assign out_tag   = tag_r[W-1];

endmodule

### hdl/rotation_matrix_to_quaternion.sv
// Channel   | Ports                      | Beat
// ----------+----------------------------+------------------------------------------
// input     | start, busy, in_item       | start high while busy low
// result    | out_valid, out_item        | out_valid high for one cycle
//
// One beat may enter every cycle; busy never rises.
// The pipeline has one setup stage, one stage per root bit of the square root, one
// overflow stage, one stage per quotient bit of the three dividers, one output stage.
// Synchronous active-low reset clears every stage's valid bit; beats in flight are dropped.
// The result side cannot stall, so the pipeline advances on every clock.
module rotation_matrix_to_quaternion (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  rmq_pkg::in_item_t  in_item,
  output logic               out_valid,
  output rmq_pkg::out_item_t out_item
);

  localparam int W = rmq_pkg::WORD_BITS;
  localparam int L = rmq_pkg::LANES;

  logic                          fv;
  logic [rmq_pkg::RAD_BITS-1:0]  frad;
  rmq_pkg::ctl_t                 fctl;
  logic                          sv;
  logic [rmq_pkg::ROOT_BITS-1:0] sroot;
  rmq_pkg::ctl_t                 sctl;
  logic                          dv;
  logic [L-1:0][W-1:0]           dquo;
  logic [L-1:0]                  dovf;
  rmq_pkg::tag_t                 dtag;

  logic                          out_valid_r;
  rmq_pkg::out_item_t            out_item_r;
  rmq_pkg::out_item_t            out_item_nxt;
  logic [L-1:0][W-1:0]           lane_val;
  logic [3:0][W-1:0]             slot_val;

  assign busy = 1'b0;

  rmq_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (start && !busy),
    .in_item  (in_item),
    .valid_r  (fv),
    .rad_r    (frad),
    .ctl_r    (fctl)
  );

  rmq_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fv),
    .rad       (frad),
    .ctl       (fctl),
    .out_valid (sv),
    .root      (sroot),
    .out_ctl   (sctl)
  );

  rmq_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sv),
    .root      (sroot),
    .ctl       (sctl),
    .out_valid (dv),
    .quo       (dquo),
    .ovf       (dovf),
    .out_tag   (dtag)
  );

  always_comb begin
    for (int l = 0; l < L; l++) begin
      if (dtag.neg[l]) begin
        lane_val[l] = (dovf[l] || (dquo[l] > rmq_pkg::WORD_MIN))
                      ? rmq_pkg::WORD_MIN : W'(-dquo[l]);
      end else begin
        lane_val[l] = (dovf[l] || (dquo[l] > rmq_pkg::WORD_MAX))
                      ? rmq_pkg::WORD_MAX : dquo[l];
      end
    end
    slot_val = '0;
    slot_val[dtag.lead]  = dtag.lead_val;
    slot_val[dtag.dst_a] = lane_val[0];
    slot_val[dtag.dst_b] = lane_val[1];
    slot_val[dtag.dst_c] = lane_val[2];
    if (dtag.bad) slot_val = '0;
    out_item_nxt.quat_w     = slot_val[rmq_pkg::SLOT_W];
    out_item_nxt.quat_x     = slot_val[rmq_pkg::SLOT_X];
    out_item_nxt.quat_y     = slot_val[rmq_pkg::SLOT_Y];
    out_item_nxt.quat_z     = slot_val[rmq_pkg::SLOT_Z];
    out_item_nxt.bad_matrix = dtag.bad;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dv;
    end
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

### hdl/rmq_chk.sv
module rmq_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input rmq_pkg::out_item_t out_item
);

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, rmq_pkg::PIPE_LATENCY))
    else $error("result beat without a matching input beat");

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.bad_matrix) |->
      (out_item.quat_w == 0 && out_item.quat_x == 0 &&
       out_item.quat_y == 0 && out_item.quat_z == 0))
    else $error("bad matrix with nonzero quaternion");

  a_good_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.bad_matrix) |->
      (out_item.quat_w != 0 || out_item.quat_x != 0 ||
       out_item.quat_y != 0 || out_item.quat_z != 0))
    else $error("good matrix gave a zero quaternion");

endmodule

bind rotation_matrix_to_quaternion rmq_chk u_rmq_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);

### tb/rotation_matrix_to_quaternion_test.sv
`timescale 1ns / 1ps

module rotation_matrix_to_quaternion_test;

  localparam int WB = rmq_pkg::WORD_BITS;
  localparam int FB = rmq_pkg::FRAC_BITS;
  localparam int S = 1 << FB;
  localparam int LIMIT = 400000;
  localparam int N_RAND = 1650;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  rmq_pkg::in_item_t in_item = '0;
  logic out_valid;
  rmq_pkg::out_item_t out_item;

  rotation_matrix_to_quaternion dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_valid(out_valid), .out_item(out_item)
  );

  always #5 clk = ~clk;

  rmq_pkg::out_item_t quat_queue[$];
  rmq_pkg::out_item_t pending_expect;
  int errors = 0;
  longint cycles = 0;

  typedef struct {
    rmq_pkg::in_item_t m;
    bit typed;
    rmq_pkg::out_item_t q;
  } row_t;

  function automatic longint wsat(longint v);
    longint hi, lo;
    hi = (64'sd1 <<< (WB - 1)) - 1;
    lo = -(64'sd1 <<< (WB - 1));
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic longint int_root(longint n);
    longint r;
    r = longint'($floor($sqrt(real'(n))));
    while (r * r > n) r--;
    while ((r + 1) * (r + 1) <= n) r++;
    return r;
  endfunction

  function automatic longint ratio(longint d, longint r);
    longint mag, q;
    mag = (d < 0) ? -d : d;
    q = ((mag <<< FB) + r) / (2 * r);
    if (q > (64'sd1 <<< WB)) q = 64'sd1 <<< WB;
    return wsat((d < 0) ? -q : q);
  endfunction

  function automatic rmq_pkg::out_item_t quat_of(rmq_pkg::in_item_t it);
    longint m[3][3];
    longint q[4];
    longint tr, rad, rt;
    int i, j, k;
    rmq_pkg::out_item_t o;
    m[0][0] = longint'(it.m00); m[0][1] = longint'(it.m01); m[0][2] = longint'(it.m02);
    m[1][0] = longint'(it.m10); m[1][1] = longint'(it.m11); m[1][2] = longint'(it.m12);
    m[2][0] = longint'(it.m20); m[2][1] = longint'(it.m21); m[2][2] = longint'(it.m22);
    q = '{0, 0, 0, 0};
    o.bad_matrix = 1'b0;
    tr = m[0][0] + m[1][1] + m[2][2];
    if (tr > 0) begin
      rt = int_root((tr + S) <<< FB);
      q[0] = wsat((rt + 1) >>> 1);
      q[1] = ratio(m[2][1] - m[1][2], rt);
      q[2] = ratio(m[0][2] - m[2][0], rt);
      q[3] = ratio(m[1][0] - m[0][1], rt);
    end else begin
      i = 0;
      if (m[1][1] > m[0][0]) i = 1;
      if (m[2][2] > m[i][i]) i = 2;
      j = (i + 1) % 3;
      k = (j + 1) % 3;
      rad = m[i][i] - m[j][j] - m[k][k] + S;
      if (rad <= 0) begin
        o.bad_matrix = 1'b1;
      end else begin
        rt = int_root(rad <<< FB);
        q[1 + i] = wsat((rt + 1) >>> 1);
        q[0] = ratio(m[k][j] - m[j][k], rt);
        q[1 + j] = ratio(m[j][i] + m[i][j], rt);
        q[1 + k] = ratio(m[k][i] + m[i][k], rt);
      end
    end
    o.quat_w = q[0][WB-1:0];
    o.quat_x = q[1][WB-1:0];
    o.quat_y = q[2][WB-1:0];
    o.quat_z = q[3][WB-1:0];
    return o;
  endfunction

  function automatic rmq_pkg::in_item_t mat(int a, int b, int c, int d, int e, int f, int g,
                                            int h, int x);
    rmq_pkg::in_item_t r;
    r.m00 = WB'(a); r.m01 = WB'(b); r.m02 = WB'(c); r.m10 = WB'(d); r.m11 = WB'(e);
    r.m12 = WB'(f); r.m20 = WB'(g); r.m21 = WB'(h); r.m22 = WB'(x);
    return r;
  endfunction

  function automatic rmq_pkg::out_item_t quat(int w, int x, int y, int z, bit b);
    rmq_pkg::out_item_t r;
    r.quat_w = WB'(w); r.quat_x = WB'(x); r.quat_y = WB'(y); r.quat_z = WB'(z);
    r.bad_matrix = b;
    return r;
  endfunction

  function automatic logic signed [WB-1:0] near_unit();
    int v;
    case ($urandom_range(0, 3))
      0: v = $urandom_range(0, 65535) - 32768;
      1: v = $urandom_range(0, 2 * S) - S;
      2: v = $urandom_range(0, 64) - 32;
      default: v = (($urandom_range(0, 1) == 1) ? S : -S) + $urandom_range(0, 8) - 4;
    endcase
    return WB'(v);
  endfunction

  function automatic rmq_pkg::in_item_t rand_rot();
    rmq_pkg::in_item_t r;
    real a, c, s;
    int ax;
    a = real'($urandom_range(0, 62831)) / 10000.0;
    c = $cos(a) * S;
    s = $sin(a) * S;
    r = mat(S, 0, 0, 0, S, 0, 0, 0, S);
    ax = $urandom_range(0, 2);
    case (ax)
      0: begin
        r.m11 = WB'(int'(c)); r.m12 = WB'(-int'(s));
        r.m21 = WB'(int'(s)); r.m22 = WB'(int'(c));
      end
      1: begin
        r.m00 = WB'(int'(c)); r.m02 = WB'(int'(s));
        r.m20 = WB'(-int'(s)); r.m22 = WB'(int'(c));
      end
      default: begin
        r.m00 = WB'(int'(c)); r.m01 = WB'(-int'(s));
        r.m10 = WB'(int'(s)); r.m11 = WB'(int'(c));
      end
    endcase
    return r;
  endfunction

  row_t dir_rows[$];

  task automatic send_beat(rmq_pkg::in_item_t it, bit idle_ok);
    int gap;
    if (idle_ok && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 7);
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && start && !busy) quat_queue.push_back(pending_expect);
  end

  always @(posedge clk) begin
    rmq_pkg::out_item_t e;
    if (rst_n && out_valid) begin
      if (quat_queue.size() == 0) begin
        $error("unexpected result beat");
        errors++;
      end else begin
        e = quat_queue.pop_front();
        if (out_item.quat_w !== e.quat_w) begin
          $error("quat_w expected %0d actual %0d", e.quat_w, out_item.quat_w); errors++;
        end
        if (out_item.quat_x !== e.quat_x) begin
          $error("quat_x expected %0d actual %0d", e.quat_x, out_item.quat_x); errors++;
        end
        if (out_item.quat_y !== e.quat_y) begin
          $error("quat_y expected %0d actual %0d", e.quat_y, out_item.quat_y); errors++;
        end
        if (out_item.quat_z !== e.quat_z) begin
          $error("quat_z expected %0d actual %0d", e.quat_z, out_item.quat_z); errors++;
        end
        if (out_item.bad_matrix !== e.bad_matrix) begin
          $error("bad_matrix expected %0d actual %0d", e.bad_matrix, out_item.bad_matrix);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic add_row(rmq_pkg::in_item_t m, bit typed, rmq_pkg::out_item_t q);
    row_t r;
    r.m = m; r.typed = typed; r.q = q;
    dir_rows.push_back(r);
  endtask

  initial begin
    rmq_pkg::in_item_t it;
    add_row(mat(S, 0, 0, 0, S, 0, 0, 0, S), 1, quat(S, 0, 0, 0, 0));
    add_row(mat(0, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0);
    add_row(mat(S, 0, 0, 0, -S, 0, 0, 0, -S), 1, quat(0, S, 0, 0, 0));
    add_row(mat(-S, 0, 0, 0, S, 0, 0, 0, -S), 1, quat(0, 0, S, 0, 0));
    add_row(mat(-S, 0, 0, 0, -S, 0, 0, 0, S), 1, quat(0, 0, 0, S, 0));
    add_row(mat(-S, 0, 0, 0, -S, 0, 0, 0, -S), 0, '0);
    add_row(mat(-32768, 0, 0, 0, -32768, 0, 0, 0, -32768), 0, '0);
    add_row(mat(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767), 0, '0);
    add_row(mat(32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767), 0, '0);
    add_row(mat(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768),
            0, '0);
    add_row(mat(1, 32767, -32768, -32768, 0, 32767, 32767, -32768, 0), 0, '0);
    add_row(mat(-1, 32767, -32768, -32768, 0, 32767, 32767, -32768, 0), 0, '0);
    add_row(mat(0, 100, 200, 300, 0, 400, 500, 600, 0), 0, '0);
    add_row(mat(-100, 5, 6, 7, -100, 8, 9, 10, -100), 0, '0);
    add_row(mat(-S, 32767, -32768, 32767, -S, -32768, 32767, -32768, 32767), 0, '0);
    add_row(mat(0, 0, 0, 0, -S, 0, 0, 0, -S), 0, '0);
    add_row(mat(0, -S, 0, S, 0, 0, 0, 0, S), 0, '0);
    add_row(mat(32767, 0, 0, 0, -32768, 0, 0, 0, 0), 0, '0);
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (dir_rows[n]) begin
      pending_expect = dir_rows[n].typed ? dir_rows[n].q : quat_of(dir_rows[n].m);
      if (dir_rows[n].typed && quat_of(dir_rows[n].m) !== dir_rows[n].q) begin
        $error("table row %0d disagrees with prediction", n); errors++;
      end
      send_beat(dir_rows[n].m, 1);
    end
    for (int n = 0; n < N_RAND; n++) begin
      if ($urandom_range(0, 2) != 0) begin
        it = rand_rot();
        it.m00 += WB'(signed'($urandom_range(0, 6)) - 3);
        it.m11 += WB'(signed'($urandom_range(0, 6)) - 3);
        it.m22 += WB'(signed'($urandom_range(0, 6)) - 3);
        it.m12 += WB'(signed'($urandom_range(0, 6)) - 3);
      end else begin
        it = mat(near_unit(), near_unit(), near_unit(), near_unit(), near_unit(),
                 near_unit(), near_unit(), near_unit(), near_unit());
      end
      pending_expect = quat_of(it);
      send_beat(it, n < N_RAND - 200);
    end
    start <= 1'b0;
    while (quat_queue.size() != 0) @(posedge clk);
    repeat (rmq_pkg::PIPE_LATENCY + 5) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
